[rtl/ssid_pkg.sv]
// ----------------------------------------------------------------------------
// ssid_pkg
// Shared types for the sorted set insert/delete unit: operation and status
// codes and the per-cell update controls.
// ----------------------------------------------------------------------------
package ssid_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_MISSING = 3'd4
    } t_status;

    typedef struct packed {
        logic cmp;   // register compare flags against the key
        logic ins;   // shift up from the insert point, key lands there
        logic del;   // shift down from the delete point
    } t_cell_ctl;

endpackage

[rtl/sorted_set_insert_delete_unit.sv]
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_unit
// Bounded set of distinct values kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one word holds i_mode (insert,
// delete, clear) and i_item_value. Output channel (o_out_valid / i_out_ready):
// one word per input word with o_status, o_entry_count, o_is_empty, o_is_full.
// On acceptance every cell registers whether it is below or equal to the key;
// at commit the status is resolved, the result word is registered and each
// cell keeps its value, takes the key, or takes its left or right neighbor's
// value. A new word is taken only once the previous one has committed: the
// compare/commit pair on the cell row holds one operation at a time.
// Reset clears the count, so the set reads as empty; stored values are not
// cleared. If the receiver stalls, the result waits in the output register,
// one more input word may be taken and is held at commit until the output
// register frees up.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [VALUE_WIDTH-1:0] i_item_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [CW-1:0]          o_entry_count,
    output logic                   o_is_empty,
    output logic                   o_is_full
);
    import ssid_pkg::*;

    logic                   r_s1_valid;
    logic [1:0]             r_mode;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    t_status                n_status;
    logic                   r_out_valid;
    t_status                r_status;
    logic [CW-1:0]          r_out_count;

    logic                   w_accept;
    logic                   w_commit;
    logic                   w_any_eq;
    logic                   w_ins_ok;
    logic                   w_del_ok;
    t_cell_ctl              w_ctl;

    logic [DEPTH-1:0]       w_lt;
    logic [DEPTH-1:0]       w_eq;
    logic [VALUE_WIDTH-1:0] w_val [DEPTH];

    assign o_in_ready = !r_s1_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign w_any_eq   = |w_eq;

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        case (r_mode)
            MODE_INSERT: begin
                if (r_count == CW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else if (w_any_eq) begin
                    n_status = ST_DUP;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            MODE_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!w_any_eq) begin
                    n_status = ST_MISSING;
                end else begin
                    w_del_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_ctl.cmp = w_accept;
    assign w_ctl.ins = w_commit && w_ins_ok;
    assign w_ctl.del = w_commit && w_del_ok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left_value;
        logic                   w_left_lt;
        logic [VALUE_WIDTH-1:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_value = r_key;
            assign w_left_lt    = 1'b1;
        end else begin : g_body
            assign w_left_value = w_val[g-1];
            assign w_left_lt    = w_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value = w_val[g];
        end else begin : g_mid
            assign w_right_value = w_val[g+1];
        end

        ssid_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_key         (w_accept ? i_item_value : r_key),
            .i_occupied    (r_count > CW'(g)),
            .i_left_value  (w_left_value),
            .i_left_lt     (w_left_lt),
            .i_right_value (w_right_value),
            .o_value       (w_val[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_commit) begin
                r_s1_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_key  <= i_item_value;
        end
        if (w_commit) begin
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = (r_out_count == '0);
    assign o_is_full     = (r_out_count == CW'(DEPTH));

endmodule

[rtl/ssid_cell.sv]
// ----------------------------------------------------------------------------
// ssid_cell
// One position of the sorted row: holds a value, registers its compare flags
// against the key, and on a commit keeps, takes the key, or takes a neighbor.
// ----------------------------------------------------------------------------
module ssid_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  ssid_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic                   i_occupied,
    input  logic [VALUE_WIDTH-1:0] i_left_value,
    input  logic                   i_left_lt,
    input  logic [VALUE_WIDTH-1:0] i_right_value,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_lt,
    output logic                   o_eq
);
    import ssid_pkg::*;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   r_lt;
    logic                   r_eq;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !r_lt) begin
            n_value = i_left_lt ? i_key : i_left_value;
        end else if (i_ctl.del && !r_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.cmp) begin
            r_lt <= i_occupied && (r_value < i_key);
            r_eq <= i_occupied && (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

[test/sorted_set_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_checker
// Watches both channels of the sorted set unit. Keeps its own copy of the
// ascending set, predicts one result word per accepted operation word and
// compares every field of each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_set_checker #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [VALUE_WIDTH-1:0] i_item_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [2:0]             i_status,
    input  logic [CW-1:0]          i_entry_count,
    input  logic                   i_is_empty,
    input  logic                   i_is_full,
    output int                     o_fail_count,
    output int                     o_pending
);
    import ssid_pkg::*;

    typedef struct packed {
        t_status       status;
        logic [CW-1:0] entry_count;
        logic          is_empty;
        logic          is_full;
    } t_set_result;

    logic [VALUE_WIDTH-1:0] set_vals [DEPTH];
    int                     set_size   = 0;
    int                     fail_total = 0;
    t_set_result            result_queue [$];

    // first slot holding a value >= key
    function automatic int find_slot(logic [VALUE_WIDTH-1:0] key);
        int i;
        i = 0;
        while (i < set_size && set_vals[i] < key) i++;
        return i;
    endfunction

    function automatic t_set_result apply_set_op(logic [1:0] op, logic [VALUE_WIDTH-1:0] key);
        t_set_result res;
        int          pos;
        res.status = ST_OK;
        pos = find_slot(key);
        case (op)
            MODE_INSERT: begin
                if (set_size == DEPTH) begin
                    res.status = ST_FULL;
                end else if (pos < set_size && set_vals[pos] == key) begin
                    res.status = ST_DUP;
                end else begin
                    for (int j = set_size; j > pos; j--) set_vals[j] = set_vals[j-1];
                    set_vals[pos] = key;
                    set_size++;
                end
            end
            MODE_DELETE: begin
                if (set_size == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= set_size || set_vals[pos] != key) begin
                    res.status = ST_MISSING;
                end else begin
                    for (int j = pos; j + 1 < set_size; j++) set_vals[j] = set_vals[j+1];
                    set_size--;
                end
            end
            MODE_CLEAR: begin
                set_size = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = CW'(set_size);
        res.is_empty    = (set_size == 0);
        res.is_full     = (set_size == DEPTH);
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_set_result want;
        if (!i_rst_n) begin
            set_size = 0;
            result_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result word with no operation waiting");
                    fail_total++;
                end else begin
                    want = result_queue.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("entry_count", 32'(want.entry_count), 32'(i_entry_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(i_is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(i_is_full));
                end
            end
            if (i_in_valid && i_in_ready) begin
                result_queue.push_back(apply_set_op(i_mode, i_item_value));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= result_queue.size();
    end

endmodule

[test/sorted_set_insert_delete_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_unit_test
// Drives directed corner cases, then random insert, delete, clear and unused-mode
// words into the sorted set unit, with phases of sender gaps and receiver stalls.
// The checker beside the unit scores the results; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete_unit_test;
    import ssid_pkg::*;

    localparam int         DEPTH        = 16;
    localparam int         VALUE_WIDTH  = 32;
    localparam int         COUNT_W      = $clog2(DEPTH + 1);
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 1850;
    localparam int         NUM_PHASES   = 8;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 20;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [1:0]             mode       = MODE_INSERT;
    logic [VALUE_WIDTH-1:0] item_value = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [2:0]             status;
    logic [COUNT_W-1:0]     entry_count;
    logic                   is_empty;
    logic                   is_full;

    int fail_count;
    int pending_count;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    sorted_set_insert_delete_unit #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (mode),
        .i_item_value  (item_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_entry_count (entry_count),
        .o_is_empty    (is_empty),
        .o_is_full     (is_full)
    );

    sorted_set_checker #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (mode),
        .i_item_value  (item_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_entry_count (entry_count),
        .i_is_empty    (is_empty),
        .i_is_full     (is_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_idling(input int profile);
        case (profile)
            0: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1: begin
                gap_pct   = 70;
                stall_pct = 0;
            end
            2: begin
                gap_pct   = 0;
                stall_pct = 70;
            end
            default: begin
                gap_pct   = 22;
                stall_pct = 22;
            end
        endcase
    endtask

    // valid stays up across back-to-back words; lowered only for a gap
    task automatic send_word(input logic [1:0] op, input logic [VALUE_WIDTH-1:0] key);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        item_value <= key;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // small value window around base gives frequent duplicates and hits
    task automatic send_random_word(input int ins_pct, input logic [VALUE_WIDTH-1:0] base);
        int                     pick;
        logic [1:0]             op;
        logic [VALUE_WIDTH-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 2) op = MODE_CLEAR;
        else if (pick < 4) op = MODE_UNUSED;
        else if (pick < 4 + ins_pct) op = MODE_INSERT;
        else op = MODE_DELETE;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = base + $urandom_range(0, 23);
        send_word(op, key);
    endtask

    initial begin
        int                     ins_pct;
        logic [VALUE_WIDTH-1:0] base;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        send_word(MODE_DELETE, '0);
        send_word(MODE_INSERT, 32'd100);
        send_word(MODE_INSERT, 32'd200);
        send_word(MODE_INSERT, '0);
        send_word(MODE_INSERT, 32'd100);
        send_word(MODE_DELETE, 32'd150);
        send_word(MODE_UNUSED, 32'hA5A5_5A5A);
        send_word(MODE_INSERT, '1);
        for (int k = 0; k < 12; k++) send_word(MODE_INSERT, 32'd3000 - k * 200);
        send_word(MODE_INSERT, 32'd5);
        send_word(MODE_INSERT, '1);
        send_word(MODE_DELETE, '1);
        send_word(MODE_DELETE, '0);
        send_word(MODE_CLEAR, 32'h5A5A_A5A5);
        send_word(MODE_DELETE, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_idling(phase % 4);
            ins_pct = $urandom_range(35, 80);
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = 32'h7FFF_FFF4;
                2: base = 32'hFFFF_FFE8;
                default: base = $urandom;
            endcase
            for (int n = 0; n < RANDOM_WORDS / NUM_PHASES; n++) send_random_word(ins_pct, base);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ssid_pkg.sv
rtl/ssid_cell.sv
rtl/sorted_set_insert_delete_unit.sv
test/sorted_set_checker.sv
test/sorted_set_insert_delete_unit_test.sv
